[sv/rlrs_pkg.sv]
package rlrs_pkg;

	localparam int COUNT_BITS = 16;
	localparam int ALU_W = 64;
	localparam int ALU_CNT_W = 8;

	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_COMPUTE = 2'd2;
	localparam logic [1:0] MODE_CLEAR = 2'd3;

	localparam logic [2:0] STAT_OK = 3'd0;
	localparam logic [2:0] STAT_EMPTY = 3'd1;
	localparam logic [2:0] STAT_ZERO_VX = 3'd2;
	localparam logic [2:0] STAT_ZERO_VY = 3'd3;
	localparam logic [2:0] STAT_COUNT_ERR = 3'd4;

	localparam logic [1:0] OP_MUL = 2'd0;
	localparam logic [1:0] OP_DIV = 2'd1;
	localparam logic [1:0] OP_SQRT = 2'd2;

	localparam logic [ALU_CNT_W-1:0] HALF_STEPS = 8'd32;

	localparam logic [ALU_W-1:0] LIM_POS = 64'h0000_0000_7FFF_FFFF;
	localparam logic [ALU_W-1:0] LIM_NEG = 64'h0000_0000_8000_0000;
	localparam logic [ALU_W-1:0] LIM_ONE = 64'h0000_0000_4000_0000;
	localparam logic [ALU_W-1:0] LIM_ALL = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic start;
		logic [1:0] op;
		logic [ALU_CNT_W-1:0] cnt;
	} alu_req_t;

endpackage

[sv/rlrs_alu.sv]
module rlrs_alu (
	input logic clk,
	input logic arst_n,
	input rlrs_pkg::alu_req_t req,
	input logic [rlrs_pkg::ALU_W-1:0] a,
	input logic [rlrs_pkg::ALU_W-1:0] b,
	input logic [rlrs_pkg::ALU_W-1:0] lim,
	output logic done,
	output logic [rlrs_pkg::ALU_W-1:0] res
);

	logic [1:0] op_q;
	logic [rlrs_pkg::ALU_CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic sticky_q;
	logic [rlrs_pkg::ALU_W-1:0] a_q;
	logic [rlrs_pkg::ALU_W-1:0] b_q;
	logic [rlrs_pkg::ALU_W-1:0] acc_q;
	logic [rlrs_pkg::ALU_W-1:0] rem_q;
	logic [rlrs_pkg::ALU_W-1:0] lim_q;
	logic [rlrs_pkg::ALU_W-1:0] res_q;

	logic [rlrs_pkg::ALU_W:0] div_rem2;
	logic [rlrs_pkg::ALU_W:0] div_diff;
	logic div_ge;
	logic [35:0] sq_rem4;
	logic [35:0] sq_trial;
	logic [35:0] sq_diff;
	logic sq_ge;

	// one quotient bit, one root bit or one multiplier bit per cycle
	assign div_rem2 = {rem_q, a_q[rlrs_pkg::ALU_W-1]};
	assign div_ge = div_rem2 >= {1'b0, b_q};
	assign div_diff = div_rem2 - {1'b0, b_q};
	assign sq_rem4 = {rem_q[33:0], a_q[rlrs_pkg::ALU_W-1 -: 2]};
	assign sq_trial = {2'b00, acc_q[31:0], 2'b01};
	assign sq_ge = sq_rem4 >= sq_trial;
	assign sq_diff = sq_rem4 - sq_trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= rlrs_pkg::OP_MUL;
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			sticky_q <= 1'b0;
			a_q <= '0;
			b_q <= '0;
			acc_q <= '0;
			rem_q <= '0;
			lim_q <= '0;
			res_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				op_q <= req.op;
				a_q <= a;
				b_q <= b;
				lim_q <= lim;
				acc_q <= '0;
				rem_q <= '0;
				sticky_q <= 1'b0;
				cnt_q <= (req.op == rlrs_pkg::OP_DIV) ? req.cnt : rlrs_pkg::HALF_STEPS;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					case (op_q)
						rlrs_pkg::OP_DIV: begin
							res_q <= (sticky_q || acc_q > lim_q) ? lim_q : acc_q;
						end
						default: begin
							res_q <= acc_q;
						end
					endcase
				end else begin
					cnt_q <= cnt_q - 1'b1;
					case (op_q)
						rlrs_pkg::OP_MUL: begin
							if (b_q[0])
								acc_q <= acc_q + a_q;
							a_q <= a_q << 1;
							b_q <= b_q >> 1;
						end
						rlrs_pkg::OP_DIV: begin
							rem_q <= div_ge ? div_diff[rlrs_pkg::ALU_W-1:0]
								: div_rem2[rlrs_pkg::ALU_W-1:0];
							acc_q <= {acc_q[rlrs_pkg::ALU_W-2:0], div_ge};
							sticky_q <= sticky_q | acc_q[rlrs_pkg::ALU_W-1];
							a_q <= a_q << 1;
						end
						default: begin
							rem_q <= sq_ge ? {30'b0, sq_diff[33:0]} : {30'b0, sq_rem4[33:0]};
							acc_q <= {acc_q[rlrs_pkg::ALU_W-2:0], sq_ge};
							a_q <= a_q << 2;
						end
					endcase
				end
			end
		end
	end

	assign done = done_q;
	assign res = res_q;

endmodule

[sv/running_linear_regression_stats.sv]
// running least-squares regression statistics
// input channel s_*: one beat per item, mode in s_tuser (add, remove, compute, clear),
// x and y as signed q8.8 in s_tdata
// output channel m_*: one beat per compute item carrying r squared, r, std dev and
// mean of y, slope, intercept and the pair count; status in m_tuser
// add and remove beats form three 16 bit products, each a pass through
// the shared serial unit
// clear and rejected add or remove beats are finished in the idle state
// in a compute beat every product, quotient and root goes through the one shared
// unit at one bit (two radicand bits) per cycle; the number of quotient steps
// depends on the fraction bits of each result
// an empty compute goes straight from idle to the output state
// only one item is worked on at a time; s_tready is high while the block is idle
// the result sits in an output register; a stalled m_tready holds it, and the next
// item is still taken, but a further compute waits for the register to free up
// reset clears the count, all sums and the error flag, and drops any pending beat
module running_linear_regression_stats (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [31:0] s_tdata, // x_value, y_value
	input logic [1:0] s_tuser, // mode
	output logic m_tvalid,
	input logic m_tready,
	// r_squared, correlation, std_dev_y, mean_y, slope, intercept, sample_count, pad
	output logic [207:0] m_tdata,
	output logic [2:0] m_tuser // status
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_PXX = 5'd1;
	localparam logic [4:0] S_PXY = 5'd2;
	localparam logic [4:0] S_PYY = 5'd3;
	localparam logic [4:0] S_CXX_M = 5'd4;
	localparam logic [4:0] S_CXX_D = 5'd5;
	localparam logic [4:0] S_CXY_M = 5'd6;
	localparam logic [4:0] S_CXY_D = 5'd7;
	localparam logic [4:0] S_CYY_M = 5'd8;
	localparam logic [4:0] S_CYY_D = 5'd9;
	localparam logic [4:0] S_MEAN = 5'd10;
	localparam logic [4:0] S_SD_D = 5'd11;
	localparam logic [4:0] S_SD_R = 5'd12;
	localparam logic [4:0] S_SLOPE = 5'd13;
	localparam logic [4:0] S_ICPT_M = 5'd14;
	localparam logic [4:0] S_ICPT_D = 5'd15;
	localparam logic [4:0] S_NORM = 5'd16;
	localparam logic [4:0] S_NUM_M = 5'd17;
	localparam logic [4:0] S_DEN_M = 5'd18;
	localparam logic [4:0] S_RR_D = 5'd19;
	localparam logic [4:0] S_R_R = 5'd20;
	localparam logic [4:0] S_OUT = 5'd21;

	localparam int CW = rlrs_pkg::COUNT_BITS;
	localparam int W = rlrs_pkg::ALU_W;

	logic [4:0] state_q;
	logic issued_q;
	logic err_q;
	logic [CW-1:0] n_q;
	logic [31:0] sx_q;
	logic [31:0] sy_q;
	logic [47:0] sxx_q;
	logic [47:0] sxy_q;
	logic [47:0] syy_q;
	logic [15:0] x_q;
	logic [15:0] y_q;
	logic sub_q;
	logic [W-1:0] cxx_q;
	logic [W-1:0] cxy_q;
	logic [W-1:0] cyy_q;
	logic [W-1:0] diff_q;
	logic [31:0] mean_q;
	logic [31:0] sd_q;
	logic [31:0] b1_q;
	logic [31:0] b0_q;
	logic [30:0] rr_q;
	logic [31:0] r_q;
	logic [W-1:0] mxy_q;
	logic [W-1:0] mx_q;
	logic [W-1:0] my_q;
	logic [5:0] exy_q;
	logic [5:0] ex_q;
	logic [5:0] ey_q;
	logic ovalid_q;
	logic [207:0] odata_q;
	logic [2:0] ouser_q;

	rlrs_pkg::alu_req_t alu_req;
	logic [W-1:0] alu_a;
	logic [W-1:0] alu_b;
	logic [W-1:0] alu_lim;
	logic alu_done;
	logic [W-1:0] alu_res;
	logic op_state;

	logic s_acc;
	logic [15:0] xmag;
	logic [15:0] ymag;
	logic [31:0] ax;
	logic [31:0] ay;
	logic [W-1:0] n64;
	logic cxx_pos;
	logic cyy_pos;
	logic [W-1:0] cxy_mag;
	logic [31:0] b1_mag;
	logic [W-1:0] diff_mag;
	logic [47:0] r48;
	logic [47:0] xy_term;
	logic [31:0] x32;
	logic [31:0] y32;
	logic [W-1:0] xy_prod;
	logic [W-1:0] b1sx;
	logic [8:0] rr_cnt;
	logic go_slope;
	logic go_rr;
	logic norm_done;
	logic [2:0] status;

	assign s_tready = (state_q == S_IDLE);
	assign s_acc = s_tvalid && s_tready;

	assign xmag = x_q[15] ? 16'(-x_q) : x_q;
	assign ymag = y_q[15] ? 16'(-y_q) : y_q;
	assign ax = sx_q[31] ? 32'(-sx_q) : sx_q;
	assign ay = sy_q[31] ? 32'(-sy_q) : sy_q;
	assign n64 = W'(n_q);
	assign cxx_pos = !cxx_q[W-1] && (cxx_q != '0);
	assign cyy_pos = !cyy_q[W-1] && (cyy_q != '0);
	assign cxy_mag = cxy_q[W-1] ? W'(-cxy_q) : cxy_q;
	assign b1_mag = b1_q[31] ? 32'(-b1_q) : b1_q;
	assign diff_mag = diff_q[W-1] ? W'(-diff_q) : diff_q;
	assign r48 = sub_q ? 48'(-alu_res[47:0]) : alu_res[47:0];
	assign xy_term = (x_q[15] ^ y_q[15] ^ sub_q) ? 48'(-alu_res[47:0]) : alu_res[47:0];
	assign x32 = {{16{x_q[15]}}, x_q};
	assign y32 = {{16{y_q[15]}}, y_q};
	assign xy_prod = (sx_q[31] ^ sy_q[31]) ? W'(-alu_res) : alu_res;
	assign b1sx = (b1_q[31] ^ sx_q[31]) ? W'(-alu_res) : alu_res;
	assign rr_cnt = 9'd94 + {2'b00, exy_q, 1'b0} - {3'b000, ex_q} - {3'b000, ey_q};
	assign go_slope = (n_q > CW'(1)) && cxx_pos;
	assign go_rr = cxx_pos && cyy_pos && (cxy_q != '0);
	assign norm_done = (mxy_q[W-1:31] == '0) && (mx_q[W-1:31] == '0)
		&& (my_q[W-1:31] == '0);

	always_comb begin
		if (err_q)
			status = rlrs_pkg::STAT_COUNT_ERR;
		else if (n_q == '0)
			status = rlrs_pkg::STAT_EMPTY;
		else if (!cxx_pos)
			status = rlrs_pkg::STAT_ZERO_VX;
		else if (!cyy_pos)
			status = rlrs_pkg::STAT_ZERO_VY;
		else
			status = rlrs_pkg::STAT_OK;
	end

	always_comb begin
		op_state = 1'b1;
		alu_req.op = rlrs_pkg::OP_MUL;
		alu_req.cnt = '0;
		alu_a = '0;
		alu_b = '0;
		alu_lim = rlrs_pkg::LIM_ALL;
		case (state_q)
			S_PXX: begin
				alu_a = W'(xmag);
				alu_b = W'(xmag);
			end
			S_PXY: begin
				alu_a = W'(xmag);
				alu_b = W'(ymag);
			end
			S_PYY: begin
				alu_a = W'(ymag);
				alu_b = W'(ymag);
			end
			S_CXX_M: begin
				alu_a = W'(ax);
				alu_b = W'(ax);
			end
			S_CXY_M: begin
				alu_a = W'(ax);
				alu_b = W'(ay);
			end
			S_CYY_M: begin
				alu_a = W'(ay);
				alu_b = W'(ay);
			end
			S_CXX_D, S_CXY_D, S_CYY_D: begin
				alu_req.op = rlrs_pkg::OP_DIV;
				alu_req.cnt = 8'd64;
				alu_a = alu_res;
				alu_b = n64;
			end
			S_MEAN: begin
				alu_req.op = rlrs_pkg::OP_DIV;
				alu_req.cnt = 8'd72;
				alu_a = W'(ay);
				alu_b = n64;
				alu_lim = sy_q[31] ? rlrs_pkg::LIM_NEG : rlrs_pkg::LIM_POS;
			end
			S_SD_D: begin
				alu_req.op = rlrs_pkg::OP_DIV;
				alu_req.cnt = 8'd80;
				alu_a = cyy_q;
				alu_b = n64;
			end
			S_SD_R: begin
				alu_req.op = rlrs_pkg::OP_SQRT;
				alu_a = alu_res;
			end
			S_SLOPE: begin
				alu_req.op = rlrs_pkg::OP_DIV;
				alu_req.cnt = 8'd80;
				alu_a = cxy_mag;
				alu_b = cxx_q;
				alu_lim = cxy_q[W-1] ? rlrs_pkg::LIM_NEG : rlrs_pkg::LIM_POS;
			end
			S_ICPT_M: begin
				alu_a = W'(b1_mag);
				alu_b = W'(ax);
			end
			S_ICPT_D: begin
				alu_req.op = rlrs_pkg::OP_DIV;
				alu_req.cnt = 8'd64;
				alu_a = diff_mag;
				alu_b = n64 << 8;
				alu_lim = diff_q[W-1] ? rlrs_pkg::LIM_NEG : rlrs_pkg::LIM_POS;
			end
			S_NUM_M: begin
				alu_a = mxy_q;
				alu_b = mxy_q;
			end
			S_DEN_M: begin
				alu_a = mx_q;
				alu_b = my_q;
			end
			S_RR_D: begin
				alu_req.op = rlrs_pkg::OP_DIV;
				alu_req.cnt = rr_cnt[7:0];
				alu_a = mxy_q;
				alu_b = mx_q;
				alu_lim = rlrs_pkg::LIM_ONE;
			end
			S_R_R: begin
				alu_req.op = rlrs_pkg::OP_SQRT;
				alu_a = W'(rr_q) << 30;
			end
			default: begin
				op_state = 1'b0;
			end
		endcase
		alu_req.start = op_state && !issued_q;
	end

	rlrs_alu u_alu (
		.clk(clk),
		.arst_n(arst_n),
		.req(alu_req),
		.a(alu_a),
		.b(alu_b),
		.lim(alu_lim),
		.done(alu_done),
		.res(alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			issued_q <= 1'b0;
			err_q <= 1'b0;
			n_q <= '0;
			sx_q <= '0;
			sy_q <= '0;
			sxx_q <= '0;
			sxy_q <= '0;
			syy_q <= '0;
			x_q <= '0;
			y_q <= '0;
			sub_q <= 1'b0;
			cxx_q <= '0;
			cxy_q <= '0;
			cyy_q <= '0;
			diff_q <= '0;
			mean_q <= '0;
			sd_q <= '0;
			b1_q <= '0;
			b0_q <= '0;
			rr_q <= '0;
			r_q <= '0;
			mxy_q <= '0;
			mx_q <= '0;
			my_q <= '0;
			exy_q <= '0;
			ex_q <= '0;
			ey_q <= '0;
			ovalid_q <= 1'b0;
			odata_q <= '0;
			ouser_q <= '0;
		end else begin
			if (state_q == S_OUT && (!ovalid_q || m_tready))
				ovalid_q <= 1'b1;
			else if (m_tready)
				ovalid_q <= 1'b0;
			if (op_state) begin
				if (!issued_q)
					issued_q <= 1'b1;
				else if (alu_done)
					issued_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						x_q <= s_tdata[15:0];
						y_q <= s_tdata[31:16];
						case (s_tuser)
							rlrs_pkg::MODE_ADD: begin
								sub_q <= 1'b0;
								if (n_q == '1)
									err_q <= 1'b1;
								else
									state_q <= S_PXX;
							end
							rlrs_pkg::MODE_REMOVE: begin
								sub_q <= 1'b1;
								if (n_q == '0)
									err_q <= 1'b1;
								else
									state_q <= S_PXX;
							end
							rlrs_pkg::MODE_CLEAR: begin
								err_q <= 1'b0;
								n_q <= '0;
								sx_q <= '0;
								sy_q <= '0;
								sxx_q <= '0;
								sxy_q <= '0;
								syy_q <= '0;
							end
							default: begin
								if (n_q == '0) begin
									sx_q <= '0;
									sy_q <= '0;
									sxx_q <= '0;
									sxy_q <= '0;
									syy_q <= '0;
									mean_q <= '0;
									sd_q <= '0;
									b1_q <= '0;
									b0_q <= '0;
									rr_q <= '0;
									r_q <= '0;
									state_q <= S_OUT;
								end else begin
									state_q <= S_CXX_M;
								end
							end
						endcase
					end
				end
				S_PXX: begin
					if (issued_q && alu_done) begin
						sxx_q <= sxx_q + r48;
						state_q <= S_PXY;
					end
				end
				S_PXY: begin
					if (issued_q && alu_done) begin
						sxy_q <= sxy_q + xy_term;
						state_q <= S_PYY;
					end
				end
				S_PYY: begin
					if (issued_q && alu_done) begin
						syy_q <= syy_q + r48;
						sx_q <= sub_q ? sx_q - x32 : sx_q + x32;
						sy_q <= sub_q ? sy_q - y32 : sy_q + y32;
						n_q <= sub_q ? n_q - 1'b1 : n_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_CXX_M: begin
					if (issued_q && alu_done)
						state_q <= S_CXX_D;
				end
				S_CXX_D: begin
					if (issued_q && alu_done) begin
						cxx_q <= {{16{sxx_q[47]}}, sxx_q} - alu_res;
						state_q <= S_CXY_M;
					end
				end
				S_CXY_M: begin
					if (issued_q && alu_done)
						state_q <= S_CXY_D;
				end
				S_CXY_D: begin
					if (issued_q && alu_done) begin
						cxy_q <= {{16{sxy_q[47]}}, sxy_q} - xy_prod;
						state_q <= S_CYY_M;
					end
				end
				S_CYY_M: begin
					if (issued_q && alu_done)
						state_q <= S_CYY_D;
				end
				S_CYY_D: begin
					if (issued_q && alu_done) begin
						cyy_q <= {{16{syy_q[47]}}, syy_q} - alu_res;
						state_q <= S_MEAN;
					end
				end
				S_MEAN: begin
					if (issued_q && alu_done) begin
						mean_q <= sy_q[31] ? 32'(-alu_res[31:0]) : alu_res[31:0];
						if (cyy_pos) begin
							state_q <= S_SD_D;
						end else begin
							sd_q <= '0;
							b1_q <= '0;
							state_q <= go_slope ? S_SLOPE : S_ICPT_M;
						end
					end
				end
				S_SD_D: begin
					if (issued_q && alu_done)
						state_q <= S_SD_R;
				end
				S_SD_R: begin
					if (issued_q && alu_done) begin
						sd_q <= alu_res[31:0];
						b1_q <= '0;
						state_q <= go_slope ? S_SLOPE : S_ICPT_M;
					end
				end
				S_SLOPE: begin
					if (issued_q && alu_done) begin
						b1_q <= cxy_q[W-1] ? 32'(-alu_res[31:0]) : alu_res[31:0];
						state_q <= S_ICPT_M;
					end
				end
				S_ICPT_M: begin
					if (issued_q && alu_done) begin
						diff_q <= {{16{sy_q[31]}}, sy_q, 16'b0} - b1sx;
						state_q <= S_ICPT_D;
					end
				end
				S_ICPT_D: begin
					if (issued_q && alu_done) begin
						b0_q <= diff_q[W-1] ? 32'(-alu_res[31:0]) : alu_res[31:0];
						mxy_q <= cxy_mag;
						mx_q <= cxx_q;
						my_q <= cyy_q;
						exy_q <= '0;
						ex_q <= '0;
						ey_q <= '0;
						if (go_rr) begin
							state_q <= S_NORM;
						end else begin
							rr_q <= '0;
							r_q <= '0;
							state_q <= S_OUT;
						end
					end
				end
				S_NORM: begin
					if (norm_done) begin
						state_q <= S_NUM_M;
					end else begin
						if (mxy_q[W-1:31] != '0) begin
							mxy_q <= mxy_q >> 1;
							exy_q <= exy_q + 1'b1;
						end
						if (mx_q[W-1:31] != '0) begin
							mx_q <= mx_q >> 1;
							ex_q <= ex_q + 1'b1;
						end
						if (my_q[W-1:31] != '0) begin
							my_q <= my_q >> 1;
							ey_q <= ey_q + 1'b1;
						end
					end
				end
				S_NUM_M: begin
					if (issued_q && alu_done) begin
						mxy_q <= alu_res;
						state_q <= S_DEN_M;
					end
				end
				S_DEN_M: begin
					if (issued_q && alu_done) begin
						mx_q <= alu_res;
						state_q <= S_RR_D;
					end
				end
				S_RR_D: begin
					if (issued_q && alu_done) begin
						rr_q <= alu_res[30:0];
						state_q <= S_R_R;
					end
				end
				S_R_R: begin
					if (issued_q && alu_done) begin
						r_q <= cxy_q[W-1] ? 32'(-alu_res[31:0]) : alu_res[31:0];
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!ovalid_q || m_tready) begin
						odata_q <= {1'b0, 16'(n_q), b0_q, b1_q, mean_q, sd_q, r_q, rr_q};
						ouser_q <= status;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata = odata_q;
	assign m_tuser = ouser_q;

endmodule
